### design/i2c_temp_sensor_poller_top_macros.svh
// Assertion helpers used by the checker file.
`ifndef I2C_TEMP_SENSOR_POLLER_TOP_MACROS_SVH
`define I2C_TEMP_SENSOR_POLLER_TOP_MACROS_SVH

// Clocked assertion, inactive while reset is asserted.
`define I2CTSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication, inactive while reset is asserted.
`define I2CTSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/i2ctsp_pkg.sv
`default_nettype none

package i2ctsp_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_POLL_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_XFER_TIMEOUT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_READY_DELAY   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDR   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [15:0] POLL_INTERVAL_RST = 16'd250;
  localparam logic [15:0] XFER_TIMEOUT_RST  = 16'd100;
  localparam logic [15:0] READY_DELAY_RST   = 16'd10;
  localparam logic [6:0]  DEVICE_ADDR_RST   = 7'd72;

  // Event codes
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_SUCCESS = 2'd1;
  localparam logic [1:0] FUNC_FAILURE = 2'd2;

  // Bus command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_WR_TIMEOUT = 3'd1;
  localparam logic [2:0] ERR_WR_FAILED  = 3'd2;
  localparam logic [2:0] ERR_RD_TIMEOUT = 3'd3;
  localparam logic [2:0] ERR_RD_FAILED  = 3'd4;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_ISSUE_WR = 3'd1;
  localparam logic [2:0] PH_WAIT_WR  = 3'd2;
  localparam logic [2:0] PH_WAIT_RDY = 3'd3;
  localparam logic [2:0] PH_ISSUE_RD = 3'd4;
  localparam logic [2:0] PH_WAIT_RD  = 3'd5;

  // Transfer status
  localparam logic [1:0] XS_WAITING = 2'd0;
  localparam logic [1:0] XS_SUCCESS = 2'd1;
  localparam logic [1:0] XS_FAILED  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_high;
    logic [7:0] rx_low;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         bus_cmd;
    logic [6:0]         bus_addr;
    logic signed [11:0] reading;
    logic               new_reading;
    logic [2:0]         error_code;
    logic [2:0]         phase;
  } out_item_t;

  typedef struct packed {
    logic [15:0] poll_interval_ms;
    logic [15:0] transfer_timeout_ms;
    logic [15:0] ready_delay_ms;
    logic [6:0]  device_addr;
  } cfg_t;

endpackage

`default_nettype wire

### design/i2ctsp_core.sv
`default_nettype none

module i2ctsp_core import i2ctsp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire in_item_t  item_i,
  input  wire cfg_t      cfg_i,
  output out_item_t      res_o
);

  logic [2:0]         phase_q, phase_d;
  logic [31:0]        now_q, now_d;
  logic [31:0]        poll_start_q, poll_start_d;
  logic [31:0]        op_start_q, op_start_d;
  logic [1:0]         status_q, status_d;
  logic signed [11:0] reading_q, reading_d;

  logic [1:0]  status_ev;
  logic [2:0]  ph;
  logic [31:0] elapsed;
  logic [15:0] limit;
  logic        over;
  logic [15:0] word;
  logic [15:0] word_adj;
  logic [1:0]  cmd;
  logic [2:0]  err;
  logic        fresh;

  // Apply the event: tick advances time, bus events latch the status
  assign now_d = (item_i.func == FUNC_TICK) ? now_q + 32'd1 : now_q;

  always_comb begin
    case (item_i.func)
      FUNC_SUCCESS: status_ev = XS_SUCCESS;
      FUNC_FAILURE: status_ev = XS_FAILED;
      default:      status_ev = status_q;
    endcase
  end

  // Only idle and the three wait phases are ever stored
  assign ph = (phase_q == PH_WAIT_WR || phase_q == PH_WAIT_RDY || phase_q == PH_WAIT_RD)
              ? phase_q : PH_IDLE;

  // One shared elapsed-time compare, start and limit picked by phase
  always_comb begin
    case (ph)
      PH_WAIT_WR,
      PH_WAIT_RD:  limit = cfg_i.transfer_timeout_ms;
      PH_WAIT_RDY: limit = cfg_i.ready_delay_ms;
      default:     limit = cfg_i.poll_interval_ms;
    endcase
  end

  assign elapsed = now_d - ((ph == PH_IDLE) ? poll_start_q : op_start_q);
  assign over    = elapsed > {16'd0, limit};

  // Signed word / 16, truncating toward zero
  assign word     = {item_i.rx_high, item_i.rx_low};
  assign word_adj = word + {12'd0, {4{word[15]}}};

  // Sequencer pass
  always_comb begin
    phase_d      = ph;
    poll_start_d = poll_start_q;
    op_start_d   = op_start_q;
    status_d     = status_ev;
    reading_d    = reading_q;
    cmd          = CMD_NONE;
    err          = ERR_NONE;
    fresh        = 1'b0;
    case (ph)
      PH_IDLE: begin
        if (over) begin
          poll_start_d = now_d;
          op_start_d   = now_d;
          status_d     = XS_WAITING;
          cmd          = CMD_WRITE;
          phase_d      = PH_WAIT_WR;
        end
      end
      PH_WAIT_WR: begin
        if (status_ev == XS_SUCCESS) begin
          op_start_d = now_d;
          phase_d    = PH_WAIT_RDY;
        end else if (status_ev == XS_FAILED) begin
          err     = ERR_WR_FAILED;
          phase_d = PH_IDLE;
        end else if (over) begin
          err     = ERR_WR_TIMEOUT;
          phase_d = PH_IDLE;
        end
      end
      PH_WAIT_RDY: begin
        if (over) begin
          op_start_d = now_d;
          status_d   = XS_WAITING;
          cmd        = CMD_READ;
          phase_d    = PH_WAIT_RD;
        end
      end
      PH_WAIT_RD: begin
        if (status_ev == XS_SUCCESS) begin
          reading_d = word_adj[15:4];
          fresh     = 1'b1;
          phase_d   = PH_IDLE;
        end else if (status_ev == XS_FAILED) begin
          err     = ERR_RD_FAILED;
          phase_d = PH_IDLE;
        end else if (over) begin
          err     = ERR_RD_TIMEOUT;
          phase_d = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      now_q        <= '0;
      poll_start_q <= '0;
      op_start_q   <= '0;
      status_q     <= XS_WAITING;
      reading_q    <= '0;
    end else if (en_i) begin
      phase_q      <= phase_d;
      now_q        <= now_d;
      poll_start_q <= poll_start_d;
      op_start_q   <= op_start_d;
      status_q     <= status_d;
      reading_q    <= reading_d;
    end
  end

  // Result of this transaction
  always_comb begin
    res_o.bus_cmd     = cmd;
    res_o.bus_addr    = (cmd != CMD_NONE) ? cfg_i.device_addr : 7'd0;
    res_o.reading     = reading_d;
    res_o.new_reading = fresh;
    res_o.error_code  = err;
    res_o.phase       = phase_d;
  end

endmodule

`default_nettype wire

### design/i2c_temp_sensor_poller_top.sv
// Temperature sensor poll sequencer.
// Input channel (in_valid_i / in_stall_o / in_data_i): one event per transaction,
// a 1 ms tick, a bus transfer success with the two received bytes, or a failure.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one result per
// input transaction, in order: bus command and address, latest reading, fresh flag,
// error code and the sequencer phase after the event.
// Config port (cfg_we_i / cfg_idx_i / cfg_data_i): single-cycle register writes,
// to be done only while no transaction is in flight.
// An accepted event is captured in the input register, and its result is then
// registered into the output register once that is free or being drained, from
// where the receiver takes it.
// Throughput: one event per cycle while no result is stalled; the sequencer update is
// one pass of compare and select logic between the input and output registers.
// A stalled result holds in the output register; the input register keeps taking
// one more event and then stall propagates to the input side in the same cycle.
// Reset: interval 250 ms, timeout 100 ms, ready delay 10 ms, address 72, phase
// idle, time and reading zero, both channels empty.
`default_nettype none

module i2c_temp_sensor_poller_top import i2ctsp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  // output channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;
  logic      advance;
  logic      in_take;

  // Stage 1 moves on when the output register is free or being drained
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_interval_ms    <= POLL_INTERVAL_RST;
      cfg_q.transfer_timeout_ms <= XFER_TIMEOUT_RST;
      cfg_q.ready_delay_ms      <= READY_DELAY_RST;
      cfg_q.device_addr         <= DEVICE_ADDR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLL_INTERVAL: cfg_q.poll_interval_ms    <= cfg_data_i;
        CFG_XFER_TIMEOUT:  cfg_q.transfer_timeout_ms <= cfg_data_i;
        CFG_READY_DELAY:   cfg_q.ready_delay_ms      <= cfg_data_i;
        CFG_DEVICE_ADDR:   cfg_q.device_addr         <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  i2ctsp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (s1_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### design/i2ctsp_checker.sv
`default_nettype none
`include "i2c_temp_sensor_poller_top_macros.svh"

module i2ctsp_checker import i2ctsp_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire out_item_t           out_data_o
);

  logic out_held;
  logic no_cmd;
  logic has_cmd;
  logic cmd_match;
  logic has_err;
  logic err_quiet;
  logic has_fresh;
  logic fresh_quiet;

  // Result channel conditions
  assign out_held    = out_valid_o && out_stall_i;
  assign no_cmd      = out_valid_o && out_data_o.bus_cmd == CMD_NONE;
  assign has_cmd     = out_valid_o && out_data_o.bus_cmd != CMD_NONE;
  assign cmd_match   = (out_data_o.bus_cmd == CMD_WRITE && out_data_o.phase == PH_WAIT_WR) ||
                       (out_data_o.bus_cmd == CMD_READ && out_data_o.phase == PH_WAIT_RD);
  assign has_err     = out_valid_o && out_data_o.error_code != ERR_NONE;
  assign err_quiet   = out_data_o.phase == PH_IDLE && out_data_o.bus_cmd == CMD_NONE &&
                       !out_data_o.new_reading;
  assign has_fresh   = out_valid_o && out_data_o.new_reading;
  assign fresh_quiet = out_data_o.phase == PH_IDLE && out_data_o.bus_cmd == CMD_NONE;

  // A stalled result stays put
  `I2CTSP_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_data_o), "result moved")

  // Address only travels with a command
  `I2CTSP_ASSERT_IMP(a_addr_idle, no_cmd, out_data_o.bus_addr == 7'd0, "address without command")

  // A command leaves the sequencer waiting for that transfer
  `I2CTSP_ASSERT_IMP(a_cmd_phase, has_cmd, cmd_match, "command and phase disagree")

  // Errors end the poll with no command
  `I2CTSP_ASSERT_IMP(a_err_idle, has_err, err_quiet, "error outside idle return")

  // A fresh reading ends a clean poll
  `I2CTSP_ASSERT_IMP(a_fresh_idle, has_fresh, fresh_quiet, "fresh reading outside idle return")

endmodule

bind i2c_temp_sensor_poller_top i2ctsp_checker u_i2ctsp_checker (.*);

`default_nettype wire
